FILE: hdl/msl_pkg.sv
`default_nettype none
package msl_pkg;

  // Level format: signed fixed point, full scale is 1 << LEVEL_FRAC_BITS
  localparam int unsigned LEVEL_FRAC_BITS = 14;

  localparam int unsigned LEVEL_W = 16;  // drive level, signed
  localparam int unsigned STEP_W  = 15;  // limit and step registers, unsigned
  localparam int unsigned US_W    = 12;  // pulse widths in microseconds
  localparam int unsigned SPAN_W  = 14;  // signed span, sign folded in
  localparam int unsigned PROD_W  = SPAN_W + LEVEL_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [STEP_W-1:0] LEVEL_LIMIT_RST   = STEP_W'(16384);
  localparam logic [STEP_W-1:0] ACCEL_STEP_RST    = STEP_W'(328);
  localparam logic [STEP_W-1:0] DECEL_STEP_RST    = STEP_W'(328);
  localparam logic [US_W-1:0]   REVERSE_END_RST   = US_W'(1000);
  localparam logic [US_W-1:0]   NEUTRAL_RST       = US_W'(1500);
  localparam logic [US_W-1:0]   FORWARD_END_RST   = US_W'(2000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_LIMIT = 3'd0,
    CFG_ACCEL_STEP  = 3'd1,
    CFG_DECEL_STEP  = 3'd2,
    CFG_REVERSE_END = 3'd3,
    CFG_NEUTRAL     = 3'd4,
    CFG_FORWARD_END = 3'd5,
    CFG_DIR_FLIP    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [STEP_W-1:0] accel_step;
    logic [STEP_W-1:0] decel_step;
  } slew_cfg_t;

endpackage
`default_nettype wire

FILE: hdl/msl_slew.sv
`default_nettype none
module msl_slew
  import msl_pkg::*;
(
  input  wire logic signed [LEVEL_W-1:0] cur_i,
  input  wire logic signed [LEVEL_W-1:0] tgt_i,
  input  wire logic                      stop_i,
  input  wire slew_cfg_t                 cfg_i,
  output logic signed [LEVEL_W-1:0]      next_o
);

  localparam int unsigned EXT_W = LEVEL_W + 2;

  logic signed [EXT_W-1:0] c_x, t_x, a_x, d_x;
  logic signed [EXT_W-1:0] c_plus_a, c_minus_a, c_plus_d, c_minus_d, neg_a, neg_t;
  logic signed [EXT_W-1:0] res;

  assign c_x = EXT_W'(cur_i);
  assign t_x = EXT_W'(tgt_i);
  assign a_x = $signed({{(EXT_W-STEP_W){1'b0}}, cfg_i.accel_step});
  assign d_x = $signed({{(EXT_W-STEP_W){1'b0}}, cfg_i.decel_step});

  assign c_plus_a  = c_x + a_x;
  assign c_minus_a = c_x - a_x;
  assign c_plus_d  = c_x + d_x;
  assign c_minus_d = c_x - d_x;
  assign neg_a     = -a_x;
  assign neg_t     = -t_x;

  // Steps limit growth of magnitude by accel, shrinkage by decel
  always_comb begin
    if (stop_i) begin
      res = '0;
    end else if (c_x > 0) begin
      if (t_x > c_plus_a)       res = c_plus_a;
      else if (t_x < c_minus_d) res = c_minus_d;
      else                      res = t_x;
    end else if (c_x < 0) begin
      if (t_x < c_minus_a)      res = c_minus_a;
      else if (t_x > c_plus_d)  res = c_plus_d;
      else                      res = t_x;
    end else begin
      if (a_x < t_x)            res = a_x;
      else if (a_x < neg_t)     res = neg_a;
      else                      res = t_x;
    end
  end

  // Result lies between the old level and the target, or is zero on a stop, so it fits
  assign next_o = res[LEVEL_W-1:0];

endmodule
`default_nettype wire

FILE: hdl/motor_command_slew_limiter.sv
`default_nettype none
// Motor command slew limiter. Each input beat either sets a target drive level
// (clamped to +/- level_limit) or forces a stop. The kept level moves toward the
// target by at most accel_step when growing in magnitude and decel_step when
// shrinking (from rest only accel_step applies); a stop zeroes it at once. Each
// beat yields one output beat with the new level (signed, 1 << 14 is full
// scale) and a servo pulse width in microseconds: neutral_us plus or minus
// floor(span * level * direction / 2^14), saturated to 0..4095. The block takes
// one beat per clock and delivers one per clock while out_stall_i is low; a beat
// passes the input register, level update, span multiply and shift/offset/
// saturate registers in that order. The level update loop sets that rate.
// Configuration writes are always ready; write registers only while no beat is
// in flight. Unlisted indexes are dropped.
module motor_command_slew_limiter
  import msl_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // command channel
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      req_type_i,
  input  wire logic signed [LEVEL_W-1:0] target_i,
  // result channel
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [LEVEL_W-1:0]      level_o,
  output logic [US_W-1:0]                pulse_us_o,
  // configuration write channel
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [STEP_W-1:0]         cfg_data_i
);

  localparam int unsigned P_W = PROD_W - LEVEL_FRAC_BITS;  // shifted product
  localparam int unsigned W_W = P_W + 1;                    // offset pulse, signed

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0] level_limit_q, accel_step_q, decel_step_q;
  logic [US_W-1:0]   reverse_end_q, neutral_q, forward_end_q;
  logic              dir_flip_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_limit_q <= LEVEL_LIMIT_RST;
      accel_step_q  <= ACCEL_STEP_RST;
      decel_step_q  <= DECEL_STEP_RST;
      reverse_end_q <= REVERSE_END_RST;
      neutral_q     <= NEUTRAL_RST;
      forward_end_q <= FORWARD_END_RST;
      dir_flip_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LEVEL_LIMIT: level_limit_q <= cfg_data_i;
        CFG_ACCEL_STEP:  accel_step_q  <= cfg_data_i;
        CFG_DECEL_STEP:  decel_step_q  <= cfg_data_i;
        CFG_REVERSE_END: reverse_end_q <= cfg_data_i[US_W-1:0];
        CFG_NEUTRAL:     neutral_q     <= cfg_data_i[US_W-1:0];
        CFG_FORWARD_END: forward_end_q <= cfg_data_i[US_W-1:0];
        CFG_DIR_FLIP:    dir_flip_q    <= cfg_data_i[0];
        default: ;  // drop writes to unlisted indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage takes a beat when it is empty or drains
  // ---------------------------------------------------------------------------
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q;
  logic a_rdy, b_rdy, c_rdy, d_rdy;

  assign d_rdy      = !d_vld_q || !out_stall_i;
  assign c_rdy      = !c_vld_q || d_rdy;
  assign b_rdy      = !b_vld_q || c_rdy;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign in_stall_o = !a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= in_valid_i;
      if (b_rdy) b_vld_q <= a_vld_q;
      if (c_rdy) c_vld_q <= b_vld_q;
      if (d_rdy) d_vld_q <= c_vld_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: clamp target to +/- level_limit and register the command
  // ---------------------------------------------------------------------------
  logic signed [LEVEL_W:0]   tgt_x, lim_x, neg_lim_x, tgt_clamp_x;
  logic signed [LEVEL_W-1:0] a_tgt_q;
  logic                      a_stop_q;

  assign tgt_x     = (LEVEL_W+1)'(target_i);
  assign lim_x     = $signed({{(LEVEL_W+1-STEP_W){1'b0}}, level_limit_q});
  assign neg_lim_x = -lim_x;

  always_comb begin
    if (tgt_x < neg_lim_x)  tgt_clamp_x = neg_lim_x;
    else if (tgt_x > lim_x) tgt_clamp_x = lim_x;
    else                    tgt_clamp_x = tgt_x;
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      a_stop_q <= req_type_i;
      a_tgt_q  <= tgt_clamp_x[LEVEL_W-1:0];  // magnitude is at most 2^15-1
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: slew-limited level update; the kept level advances with the beat
  // ---------------------------------------------------------------------------
  slew_cfg_t                 slew_cfg;
  logic signed [LEVEL_W-1:0] next_level;
  logic signed [LEVEL_W-1:0] cur_level_q;
  logic signed [LEVEL_W-1:0] b_level_q;

  assign slew_cfg.accel_step = accel_step_q;
  assign slew_cfg.decel_step = decel_step_q;

  msl_slew u_slew (
    .cur_i  (cur_level_q),
    .tgt_i  (a_tgt_q),
    .stop_i (a_stop_q),
    .cfg_i  (slew_cfg),
    .next_o (next_level)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_level_q <= '0;
    end else if (a_vld_q && b_rdy) begin
      cur_level_q <= next_level;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_rdy) b_level_q <= next_level;
  end

  // ---------------------------------------------------------------------------
  // Stage C: span toward the active end, direction folded in, one multiply
  // ---------------------------------------------------------------------------
  logic signed [SPAN_W-1:0] span, span_dir;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] c_prod_q;
  logic signed [LEVEL_W-1:0] c_level_q;

  always_comb begin
    if (b_level_q > 0) begin
      span = $signed({2'b00, forward_end_q}) - $signed({2'b00, neutral_q});
    end else begin
      span = $signed({2'b00, reverse_end_q}) - $signed({2'b00, neutral_q});
    end
    span_dir = dir_flip_q ? -span : span;
  end

  assign prod = PROD_W'(span_dir) * PROD_W'(b_level_q);

  always_ff @(posedge clk_i) begin
    if (c_rdy) begin
      c_prod_q  <= prod;
      c_level_q <= b_level_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: floor shift, offset from neutral, saturate; result register
  // ---------------------------------------------------------------------------
  logic signed [P_W-1:0]  pdelta;
  logic signed [W_W-1:0]  neutral_x, width_x;
  logic [US_W-1:0]        pulse_sat;
  logic signed [LEVEL_W-1:0] d_level_q;
  logic [US_W-1:0]        d_pulse_q;

  assign pdelta    = P_W'(c_prod_q >>> LEVEL_FRAC_BITS);
  assign neutral_x = $signed({{(W_W-US_W){1'b0}}, neutral_q});

  always_comb begin
    if (c_level_q > 0)      width_x = neutral_x + W_W'(pdelta);
    else if (c_level_q < 0) width_x = neutral_x - W_W'(pdelta);
    else                    width_x = neutral_x;

    if (width_x < 0) begin
      pulse_sat = '0;
    end else if (width_x > $signed({{(W_W-US_W){1'b0}}, {US_W{1'b1}}})) begin
      pulse_sat = '1;
    end else begin
      pulse_sat = width_x[US_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_rdy) begin
      d_level_q <= c_level_q;
      d_pulse_q <= pulse_sat;
    end
  end

  assign out_valid_o = d_vld_q;
  assign level_o     = d_level_q;
  assign pulse_us_o  = d_pulse_q;

endmodule
`default_nettype wire
